### src/ntp_pkg.sv
// Shared types, widths and factor tables for the note-to-pitch converter.
// No dependencies; imported by the converter core.
package ntp_pkg;

  localparam int NoteIdxW   = 4;
  localparam int FineIdxW   = 7;
  localparam int ShiftW     = 5;
  localparam int FactorW    = 16;
  localparam int BiasedW    = 9;
  localparam int OffsetBias = 264;
  // Octaves below this quotient of the biased offset are shifted down.
  localparam int NoShiftQuot = 24;
  // Reciprocal of 12 scaled by 2^13; exact floor for biased values up to 392.
  localparam int RecipTwelve = 683;
  localparam int RecipShift  = 13;

  typedef logic [FactorW-1:0] factor_t;

  function automatic factor_t semi_factor(input logic [NoteIdxW-1:0] idx);
    factor_t f;
    unique case (idx)
      4'd0:    f = 16'h8000;
      4'd1:    f = 16'h879C;
      4'd2:    f = 16'h8FAC;
      4'd3:    f = 16'h9837;
      4'd4:    f = 16'hA145;
      4'd5:    f = 16'hAADC;
      4'd6:    f = 16'hB504;
      4'd7:    f = 16'hBFC8;
      4'd8:    f = 16'hCB2F;
      4'd9:    f = 16'hD744;
      4'd10:   f = 16'hE411;
      4'd11:   f = 16'hF1A1;
      default: f = 16'h8000;
    endcase
    return f;
  endfunction

  localparam factor_t FineRom [128] = '{
    16'h8000, 16'h800E, 16'h801D, 16'h802C, 16'h803B, 16'h804A, 16'h8058, 16'h8067,
    16'h8076, 16'h8085, 16'h8094, 16'h80A3, 16'h80B1, 16'h80C0, 16'h80CF, 16'h80DE,
    16'h80ED, 16'h80FC, 16'h810B, 16'h811A, 16'h8129, 16'h8138, 16'h8146, 16'h8155,
    16'h8164, 16'h8173, 16'h8182, 16'h8191, 16'h81A0, 16'h81AF, 16'h81BE, 16'h81CD,
    16'h81DC, 16'h81EB, 16'h81FA, 16'h8209, 16'h8218, 16'h8227, 16'h8236, 16'h8245,
    16'h8254, 16'h8263, 16'h8272, 16'h8282, 16'h8291, 16'h82A0, 16'h82AF, 16'h82BE,
    16'h82CD, 16'h82DC, 16'h82EB, 16'h82FA, 16'h830A, 16'h8319, 16'h8328, 16'h8337,
    16'h8346, 16'h8355, 16'h8364, 16'h8374, 16'h8383, 16'h8392, 16'h83A1, 16'h83B0,
    16'h83C0, 16'h83CF, 16'h83DE, 16'h83ED, 16'h83FD, 16'h840C, 16'h841B, 16'h842A,
    16'h843A, 16'h8449, 16'h8458, 16'h8468, 16'h8477, 16'h8486, 16'h8495, 16'h84A5,
    16'h84B4, 16'h84C3, 16'h84D3, 16'h84E2, 16'h84F1, 16'h8501, 16'h8510, 16'h8520,
    16'h852F, 16'h853E, 16'h854E, 16'h855D, 16'h856D, 16'h857C, 16'h858B, 16'h859B,
    16'h85AA, 16'h85BA, 16'h85C9, 16'h85D9, 16'h85E8, 16'h85F8, 16'h8607, 16'h8617,
    16'h8626, 16'h8636, 16'h8645, 16'h8655, 16'h8664, 16'h8674, 16'h8683, 16'h8693,
    16'h86A2, 16'h86B2, 16'h86C1, 16'h86D1, 16'h86E0, 16'h86F0, 16'h8700, 16'h870F,
    16'h871F, 16'h872E, 16'h873E, 16'h874E, 16'h875D, 16'h876D, 16'h877D, 16'h878C
  };

endpackage

### src/note_to_pitch_converter_core.sv
// Note-to-pitch converter core: index split, factor tables, multiply, rounding shift.
// Depends on ntp_pkg for the factor tables and widths.

// The core takes one note item per cycle while its output is not stalled and
// returns one 16-bit pitch word for each. Every item passes through four
// registers (input, table indices, scaled product, result), and m_tvalid rises
// when the item reaches the result register. The pipeline stalls only while
// the result register holds an item that has not been taken; s_tready then
// drops as the stages behind it fill up.
module note_to_pitch_converter_core
  import ntp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] reference note, [14:8] reference fine tune, [21:15] played_note,
  // [29:22] played_fine (signed), [31:30] zero
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] pitch_word
  output logic [15:0] m_tdata
);

  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  // Stage 1: input register.
  logic [7:0]        ref_note;
  logic [6:0]        ref_fine;
  logic [6:0]        played_note;
  logic signed [7:0] played_fine;

  // Stage 2: table indices and shift amount.
  logic [NoteIdxW-1:0] semi_sel;
  logic [FineIdxW-1:0] fine_sel;
  logic [ShiftW-1:0]   shift2;

  // Stage 3: scaled product and shift amount.
  logic [FactorW-1:0] prod;
  logic [ShiftW-1:0]  shift3;

  assign adv3     = !m_tvalid || m_tready;
  assign adv2     = !v3 || adv3;
  assign adv1     = !v2 || adv2;
  assign s_tready = !v1 || adv1;

  // Index split.
  logic signed [8:0] fine_sum;
  logic signed [1:0] carry;
  logic signed [9:0] note_off;
  logic [BiasedW-1:0] biased;
  logic [18:0]        quot_full;
  logic [5:0]         quot;
  logic [BiasedW-1:0] rem;
  logic [ShiftW-1:0]  shift_calc;

  always_comb begin
    fine_sum  = 9'(played_fine) + $signed({2'b00, ref_fine});
    carry     = fine_sum[8:7];
    note_off  = $signed({3'b000, played_note}) + 10'(carry) - $signed({2'b00, ref_note});
    biased    = BiasedW'(note_off + 10'(OffsetBias));
    quot_full = 19'(biased) * 19'(RecipTwelve);
    quot      = quot_full[RecipShift +: 6];
    rem       = biased - BiasedW'(quot) * BiasedW'(12);
    if (quot >= 6'(NoShiftQuot)) begin
      shift_calc = '0;
    end else begin
      shift_calc = ShiftW'(6'(NoShiftQuot) - quot);
    end
  end

  // Factor product; the upper half stays below 0x8000.
  logic [2*FactorW-1:0] full_prod;
  assign full_prod = semi_factor(semi_sel) * FineRom[fine_sel];

  // Right shift rounding half up, done on the product doubled so that the
  // half bit sits at position zero.
  logic [FactorW:0] dbl_shifted;
  logic [FactorW:0] rounded;
  logic [15:0]      pitch_calc;

  always_comb begin
    if (shift3 == '0) begin
      dbl_shifted = '0;
      rounded     = '0;
      pitch_calc  = prod;
    end else begin
      dbl_shifted = {prod, 1'b0} >> shift3;
      rounded     = dbl_shifted + (FactorW+1)'(1);
      pitch_calc  = rounded[FactorW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) v1 <= s_tvalid;
      if (adv1) v2 <= v1;
      if (adv2) v3 <= v2;
      if (adv3) m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ref_note    <= s_tdata[7:0];
      ref_fine    <= s_tdata[14:8];
      played_note <= s_tdata[21:15];
      played_fine <= s_tdata[29:22];
    end
    if (v1 && adv1) begin
      semi_sel <= rem[NoteIdxW-1:0];
      fine_sel <= fine_sum[FineIdxW-1:0];
      shift2   <= shift_calc;
    end
    if (v2 && adv2) begin
      prod   <= full_prod[2*FactorW-1:FactorW];
      shift3 <= shift2;
    end
    if (v3 && adv3) begin
      m_tdata <= pitch_calc;
    end
  end

endmodule

### src/ntp_checker.sv
// Port-level checks for the note-to-pitch converter core, bound into the core module.
// Depends only on the core's ports.
module ntp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A result that is not taken stays in place.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Input back-pressure only comes from a stalled result.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a stalled result");

  // The table product never reaches 0x8000, and shifts only lower it.
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[15])
    else $error("pitch word out of range");

endmodule

bind note_to_pitch_converter_core ntp_checker u_ntp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
